FILE: design/hbm_pkg.sv
// ----------------------------------------------------------------------------
// hbm_pkg
// shared types, constants and bit-scan helpers for the hierarchical bitmap
// ----------------------------------------------------------------------------
package hbm_pkg;

   localparam int WordBits  = 32;
   localparam int PosBits   = 5;
   localparam int IndexBits = 15;
   localparam int StoreWords = 1057;
   localparam int AddrBits  = 11;
   localparam int SubWordsL2 = 33;
   localparam int SubWordsL1 = 1;

   typedef logic [WordBits-1:0]  word_type;
   typedef logic [AddrBits-1:0]  addr_type;
   typedef logic [PosBits-1:0]   pos_type;
   typedef logic [IndexBits-1:0] index_type;
   typedef logic [1:0]           mode_type;

   localparam mode_type MODE_TEST  = 2'd0;
   localparam mode_type MODE_SET   = 2'd1;
   localparam mode_type MODE_CLEAR = 2'd2;

   // memory access request from the sequencer
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
      addr_type rd_addr;
   } mem_req_type;

   function automatic pos_type lowest_one(input word_type w);
      pos_type r;
      r = '0;
      for (int k = WordBits - 1; k >= 0; k--) begin
         if (w[k]) r = pos_type'(k);
      end
      return r;
   endfunction

   function automatic pos_type highest_one(input word_type w);
      pos_type r;
      r = '0;
      for (int k = 0; k < WordBits; k++) begin
         if (w[k]) r = pos_type'(k);
      end
      return r;
   endfunction

endpackage

FILE: design/hbm_store.sv
// ----------------------------------------------------------------------------
// hbm_store
// word store with separate write and read addresses and registered read data
// ----------------------------------------------------------------------------
module hbm_store (
   input  logic                clock,
   input  hbm_pkg::mem_req_type req,
   output hbm_pkg::word_type    rd_data
);
   import hbm_pkg::*;

   word_type mem [StoreWords];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data_ff <= mem[req.rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/hierarchical_bitmap_top.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_top
// three-level bitmap of 32-bit words with set, clear, test and min/max scan
// ----------------------------------------------------------------------------
// After reset a clearing pass writes zero to all 1057 words with req_ready
// low. Each transaction then runs on the word store under a sequencer: reads
// of the three path words, up to three writes, and two three-word downward
// scans for the lowest and highest set index. One transaction is in flight
// at a time; req_ready rises again once the result is taken.
module hierarchical_bitmap_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hbm_pkg::mode_type    req_mode,
   input  hbm_pkg::index_type   req_bit_index,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_was_set,
   output logic                 rsp_any_set,
   output hbm_pkg::index_type   rsp_min_index,
   output hbm_pkg::index_type   rsp_max_index
);
   import hbm_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_READ, S_UPD, S_SCAN, S_DONE
   } state_type;

   state_type   state_ff;
   addr_type    clr_ff;
   mode_type    mode_ff;
   pos_type     pos_ff [3];
   addr_type    addr_ff [3];
   word_type    word_ff [3];
   logic [1:0]  lvl_ff;
   logic        phase_ff;
   logic        hi_ff;
   logic        clr_go_ff;
   addr_type    sa_ff;
   index_type   sidx_ff;
   logic        was_ff, any_ff;
   index_type   min_ff, max_ff;
   logic        rsp_valid_ff;

   mem_req_type req;
   word_type    rd_data;
   word_type    nw;
   pos_type     p;

   hbm_store u_store (.clock(clock), .req(req), .rd_data(rd_data));

   assign p = hi_ff ? highest_one(rd_data) : lowest_one(rd_data);

   // updated word for the level being written
   always_comb begin
      nw = word_ff[lvl_ff];
      if (mode_ff == MODE_SET) nw[pos_ff[lvl_ff]] = 1'b1;
      else                     nw[pos_ff[lvl_ff]] = 1'b0;
   end

   always_comb begin
      req = '0;
      unique case (state_ff)
         S_CLEAR: begin
            req.wr_en   = 1'b1;
            req.wr_addr = clr_ff;
         end
         S_READ: req.rd_addr = addr_ff[lvl_ff];
         S_UPD: begin
            req.wr_en   = phase_ff;
            req.wr_addr = addr_ff[lvl_ff];
            req.wr_data = nw;
         end
         S_SCAN: req.rd_addr = sa_ff;
         default: ;
      endcase
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_was_set   = was_ff;
   assign rsp_any_set   = any_ff;
   assign rsp_min_index = min_ff;
   assign rsp_max_index = max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == addr_type'(StoreWords - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff    <= req_mode;
                  pos_ff[2]  <= req_bit_index[14:10];
                  pos_ff[1]  <= req_bit_index[9:5];
                  pos_ff[0]  <= req_bit_index[4:0];
                  addr_ff[2] <= '0;
                  addr_ff[1] <= addr_type'(req_bit_index[14:10]) * addr_type'(SubWordsL2)
                                + addr_type'(1);
                  addr_ff[0] <= addr_type'(req_bit_index[14:10]) * addr_type'(SubWordsL2)
                                + addr_type'(req_bit_index[9:5]) + addr_type'(2);
                  lvl_ff     <= 2'd2;
                  phase_ff   <= 1'b0;
                  state_ff   <= S_READ;
               end
            end
            S_READ: begin
               // read issued this cycle, data lands the next
               if (phase_ff) begin
                  word_ff[lvl_ff] <= rd_data;
                  phase_ff        <= 1'b0;
                  if (lvl_ff == 2'd0) begin
                     was_ff    <= rd_data[pos_ff[0]];
                     clr_go_ff <= 1'b1;
                     state_ff  <= S_UPD;
                  end else begin
                     lvl_ff   <= lvl_ff - 1'b1;
                  end
               end else begin
                  phase_ff <= 1'b1;
               end
            end
            S_UPD: begin
               // lvl walks 0 -> 2; write while allowed
               if (!phase_ff) begin
                  if (mode_ff == MODE_SET || (mode_ff == MODE_CLEAR && clr_go_ff)) begin
                     phase_ff <= 1'b1;
                  end else begin
                     hi_ff <= 1'b0; lvl_ff <= 2'd2; sa_ff <= '0;
                     sidx_ff <= '0; state_ff <= S_SCAN;
                  end
               end else begin
                  phase_ff <= 1'b0;
                  word_ff[lvl_ff] <= nw;
                  clr_go_ff <= (mode_ff == MODE_CLEAR) ? (nw == '0) : 1'b1;
                  if (lvl_ff == 2'd2) begin
                     hi_ff <= 1'b0; lvl_ff <= 2'd2; sa_ff <= '0;
                     sidx_ff <= '0; state_ff <= S_SCAN;
                  end else begin
                     lvl_ff <= lvl_ff + 1'b1;
                  end
               end
            end
            S_SCAN: begin
               if (phase_ff) begin
                  phase_ff <= 1'b0;
                  unique case (lvl_ff)
                     2'd2: begin
                        any_ff  <= (rd_data != '0);
                        sidx_ff <= index_type'(p) << 10;
                        sa_ff   <= addr_type'(p) * addr_type'(SubWordsL2) + addr_type'(1);
                        lvl_ff  <= 2'd1;
                     end
                     2'd1: begin
                        sidx_ff <= sidx_ff | (index_type'(p) << 5);
                        sa_ff   <= sa_ff + addr_type'(p) + addr_type'(SubWordsL1);
                        lvl_ff  <= 2'd0;
                     end
                     default: begin
                        if (!hi_ff) begin
                           min_ff <= any_ff ? (sidx_ff | index_type'(p)) : '0;
                           hi_ff  <= 1'b1;
                           lvl_ff <= 2'd2;
                           sa_ff  <= '0;
                        end else begin
                           max_ff <= any_ff ? (sidx_ff | index_type'(p)) : '0;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= S_DONE;
                        end
                     end
                  endcase
               end else begin
                  phase_ff <= 1'b1;
               end
            end
            S_DONE: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_ready_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_clear_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready) else $error("accept during clear");
endmodule

FILE: dv/tb_hierarchical_bitmap_top.sv
// ----------------------------------------------------------------------------
// tb_hierarchical_bitmap_top
// checks test, set and clear transactions and the occupancy report (any set,
// lowest and highest set index) against a flat bit-array predictor of the map
// ----------------------------------------------------------------------------
module tb_hierarchical_bitmap_top;
   import hbm_pkg::*;

   typedef struct packed {
      logic      was_set;
      logic      any_set;
      index_type min_index;
      index_type max_index;
   } occupancy_type;

   localparam int MapBits    = 32768;
   localparam int CycleLimit = 2000000;
   // unused mode code, behaves as a test
   localparam mode_type MODE_RESERVED = 2'd3;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   mode_type  req_mode;
   index_type req_bit_index;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_was_set;
   logic      rsp_any_set;
   index_type rsp_min_index;
   index_type rsp_max_index;

   logic          map_bits [MapBits];
   occupancy_type expected_occupancy [$];
   int            mismatch_count;
   int            result_count;
   int            sent_count;
   int            cycle_count;
   int            send_idle_pct;
   int            recv_idle_pct;
   int            set_count;
   int            clear_count;

   hierarchical_bitmap_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_bit_index(req_bit_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_was_set(rsp_was_set), .rsp_any_set(rsp_any_set),
      .rsp_min_index(rsp_min_index), .rsp_max_index(rsp_max_index)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_hierarchical_bitmap_top NOT OK");
         $finish;
      end
   end

   function automatic occupancy_type predict_occupancy(input mode_type mode,
                                                       input index_type idx);
      occupancy_type r;
      r = '0;
      r.was_set = map_bits[idx];
      if (mode == MODE_SET) map_bits[idx] = 1'b1;
      else if (mode == MODE_CLEAR) map_bits[idx] = 1'b0;
      for (int k = 0; k < MapBits; k++) begin
         if (map_bits[k]) begin
            if (!r.any_set) r.min_index = index_type'(k);
            r.any_set   = 1'b1;
            r.max_index = index_type'(k);
         end
      end
      return r;
   endfunction

   // receiver side: random stall, compare every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            occupancy_type got, exp;
            got = {rsp_was_set, rsp_any_set, rsp_min_index, rsp_max_index};
            result_count <= result_count + 1;
            if (expected_occupancy.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
               exp = expected_occupancy.pop_front();
               if (got !== exp) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= 10)
                     $display("mismatch: was %b/%b any %b/%b min %0d/%0d max %0d/%0d",
                              exp.was_set, got.was_set, exp.any_set, got.any_set,
                              exp.min_index, got.min_index, exp.max_index,
                              got.max_index);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // valid is dropped only when the sender idles or the stream drains
   task automatic send_op(input mode_type mode, input index_type idx);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_bit_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_occupancy.push_back(predict_occupancy(mode, idx));
      sent_count = sent_count + 1;
      if (mode == MODE_SET) set_count = set_count + 1;
      if (mode == MODE_CLEAR) clear_count = clear_count + 1;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_occupancy.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(MODE_TEST, 15'd0);
      send_op(MODE_CLEAR, 15'd0);
      send_op(MODE_SET, 15'd0);
      send_op(MODE_SET, 15'd0);
      send_op(MODE_SET, 15'h7fff);
      send_op(MODE_TEST, 15'h7fff);
      send_op(MODE_SET, 15'h5555);
      send_op(MODE_SET, 15'h2aaa);
      send_op(MODE_CLEAR, 15'd0);
      send_op(MODE_CLEAR, 15'h7fff);
      send_op(MODE_RESERVED, 15'h5555);
      send_op(MODE_CLEAR, 15'h5555);
      send_op(MODE_CLEAR, 15'h2aaa);
      send_op(MODE_TEST, 15'h2aaa);
      send_op(MODE_SET, 15'd31);
      send_op(MODE_SET, 15'd32);
      send_op(MODE_SET, 15'd1023);
      send_op(MODE_SET, 15'd1024);
      send_op(MODE_CLEAR, 15'd32);
      send_op(MODE_CLEAR, 15'd1024);
      send_op(MODE_CLEAR, 15'd31);
      send_op(MODE_CLEAR, 15'd1023);
      send_op(MODE_RESERVED, 15'd0);
   endtask

   // mostly ops clustered in a small window so clears empty whole subtrees
   task automatic test_random(input int count);
      index_type base, idx;
      int        sel;
      base = index_type'($urandom);
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 5) base = index_type'($urandom);
         if (sel < 70) idx = base ^ index_type'($urandom_range(63));
         else if (sel < 85) idx = index_type'($urandom);
         else idx = $urandom_range(1) ? 15'h7fff : 15'd0;
         sel = $urandom_range(99);
         send_op(sel < 45 ? MODE_SET : sel < 85 ? MODE_CLEAR :
                 sel < 95 ? MODE_TEST : MODE_RESERVED, idx);
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_TEST;
      req_bit_index  = '0;
      mismatch_count = 0;
      result_count   = 0;
      sent_count     = 0;
      cycle_count    = 0;
      set_count      = 0;
      clear_count    = 0;
      send_idle_pct  = 33;
      recv_idle_pct  = 77;
      for (int k = 0; k < MapBits; k++) map_bits[k] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      drain_results();
      test_random(260);
      send_idle_pct = 77;
      recv_idle_pct = 33;
      test_random(260);
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(260);
      drain_results();
      repeat (40) @(posedge clock);
      $display("covered %0d transactions (%0d sets, %0d clears), %0d results checked",
               sent_count, set_count, clear_count, result_count);
      if (mismatch_count == 0 && expected_occupancy.size() == 0) begin
         $display("tb_hierarchical_bitmap_top OK");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_hierarchical_bitmap_top NOT OK");
      end
      $finish;
   end

endmodule

FILE: hierarchical_bitmap_top.f
design/hbm_pkg.sv
design/hbm_store.sv
design/hierarchical_bitmap_top.sv
dv/tb_hierarchical_bitmap_top.sv
